@@ rtl/core/tlc_pkg.sv @@
// Shared constants, codes and types of the two-level write-back cache.
package tlc_pkg;

    // Default geometry: sizes in bytes and the L2 way count
    localparam int BLOCK_BYTES_DEF = 16;
    localparam int L1_BYTES_DEF    = 256;
    localparam int L2_BYTES_DEF    = 512;
    localparam int L2_WAYS_DEF     = 2;
    localparam int MEM_BYTES_DEF   = 65536;

    // Fixed word size, request address width and field widths
    localparam int WORD_BYTES = 4;
    localparam int ADDR_W     = 16;
    localparam int WORD_W     = 32;
    localparam int COST_W     = 8;
    localparam int ACC_W      = 12;

    // Configuration register indexes
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_L1_RD  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_L1_WR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_L2_RD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_L2_WR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MEM_RD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MEM_WR = 3'd5;

    typedef logic [COST_W-1:0] t_cost;

    localparam t_cost COST_L1_RD_RST  = 8'd1;
    localparam t_cost COST_L1_WR_RST  = 8'd1;
    localparam t_cost COST_L2_RD_RST  = 8'd10;
    localparam t_cost COST_L2_WR_RST  = 8'd10;
    localparam t_cost COST_MEM_RD_RST = 8'd100;
    localparam t_cost COST_MEM_WR_RST = 8'd50;

    // Block copy kinds
    typedef logic [1:0] t_copy;
    localparam t_copy CP_L2_MEM = 2'd0;
    localparam t_copy CP_MEM_L2 = 2'd1;
    localparam t_copy CP_L1_L2  = 2'd2;
    localparam t_copy CP_L2_L1  = 2'd3;

    // Index width of at least one bit
    function automatic int clog2_min1(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

@@ rtl/core/tlc_ram.sv @@
// Simple dual-port synchronous RAM with registered read.
module tlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [tlc_pkg::clog2_min1(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [tlc_pkg::clog2_min1(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/two_level_writeback_cache.sv @@
// Top level of the two-level write-back cache with backing memory.
//
// Requests enter on the s_axis channel (tuser = req_type, tdata = byte_address,
// write_word) and one result per request leaves on m_axis (tdata = read_word,
// l1_hit, l2_hit, access_cost, elapsed_time). Cost registers are written on the
// cfg port by the user only while the block is idle; the block does not enforce it.
// One request is worked on at a time; the sequencer walks the memories.
// An L1 hit goes through accept, tag check, word access and result load for a
// write, with one more step for the registered word read on a read. An L1 miss
// adds an L2 tag scan for each L2 access (two accesses when the L1 victim is
// dirty) plus a block copy for each of the L1 victim write-back, L2 victim
// write-back, L2 fill from memory and L1 fill, each copy moving one word a
// cycle through the single read port of its source RAM.
// After reset the backing memory is cleared one word a cycle, every word in
// turn (16384 words at the defaults); no request is taken until it is done.
// The finished result sits in an output register: the next request is taken
// while it waits. If a second result is ready before the first is taken,
// the sequencer holds until m_axis_tready.
module two_level_writeback_cache #(
    parameter int BLOCK_BYTES = tlc_pkg::BLOCK_BYTES_DEF,
    parameter int L1_BYTES    = tlc_pkg::L1_BYTES_DEF,
    parameter int L2_BYTES    = tlc_pkg::L2_BYTES_DEF,
    parameter int L2_WAYS     = tlc_pkg::L2_WAYS_DEF,
    parameter int MEM_BYTES   = tlc_pkg::MEM_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [47:0]                   s_axis_tdata,  // byte_address[15:0], write_word
    input  logic                          s_axis_tuser,  // req_type
    // Result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [79:0]                   m_axis_tdata,  // read_word, l1_hit, l2_hit,
                                                         // access_cost, elapsed_time, pad
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [tlc_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlc_pkg::COST_W-1:0]    i_cfg_data
);

    // Geometry
    localparam int WB        = tlc_pkg::WORD_BYTES;
    localparam int WPB       = BLOCK_BYTES / WB;
    localparam int OB        = $clog2(BLOCK_BYTES);
    localparam int L1_SLOTS  = L1_BYTES / BLOCK_BYTES;
    localparam int L2_SETS   = L2_BYTES / (BLOCK_BYTES * L2_WAYS);
    localparam int L2_SLOTS  = L2_SETS * L2_WAYS;
    localparam int MEM_LOG   = $clog2(MEM_BYTES);
    localparam int AW        = (MEM_LOG < tlc_pkg::ADDR_W) ? MEM_LOG : tlc_pkg::ADDR_W;
    localparam int MEM_WORDS = (1 << AW) / WB;
    localparam int BLKS      = (1 << AW) / BLOCK_BYTES;
    localparam int BLK_W     = AW - OB;
    localparam int I1W       = tlc_pkg::clog2_min1(L1_SLOTS);
    localparam int T1W       = tlc_pkg::clog2_min1(BLKS / L1_SLOTS);
    localparam int SW        = tlc_pkg::clog2_min1(L2_SETS);
    localparam int T2W       = tlc_pkg::clog2_min1(BLKS / L2_SETS);
    localparam int WYW       = tlc_pkg::clog2_min1(L2_WAYS);
    localparam int LW        = tlc_pkg::clog2_min1(L2_SLOTS);
    localparam int KW        = tlc_pkg::clog2_min1(WPB);
    localparam int CW        = $clog2(WPB + 1);
    localparam int L1WA      = tlc_pkg::clog2_min1(L1_SLOTS * WPB);
    localparam int L2WA      = tlc_pkg::clog2_min1(L2_SLOTS * WPB);
    localparam int MWA       = tlc_pkg::clog2_min1(MEM_WORDS);
    localparam int MTW       = tlc_pkg::WORD_W + T2W;
    localparam int DW        = tlc_pkg::WORD_W;

    // Sequencer states
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_L1TAG = 4'd2;
    localparam logic [3:0] S_L2RD  = 4'd3;
    localparam logic [3:0] S_L2CK  = 4'd4;
    localparam logic [3:0] S_L2SEL = 4'd5;
    localparam logic [3:0] S_COPY  = 4'd6;
    localparam logic [3:0] S_AFTER = 4'd7;
    localparam logic [3:0] S_WORD  = 4'd8;
    localparam logic [3:0] S_WRD   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    // Control registers
    logic [3:0]              r_state;
    logic [CW-1:0]           r_cnt;
    logic [WYW-1:0]          r_way;
    logic [MWA-1:0]          r_clr;
    logic                    r_out_vld;
    logic [L1_SLOTS-1:0]     r_l1_valid;
    logic [L1_SLOTS-1:0]     r_l1_dirty;
    logic [L2_SLOTS-1:0]     r_l2_valid;
    logic [L2_SLOTS-1:0]     r_l2_dirty;
    logic [DW-1:0]           r_time;
    tlc_pkg::t_cost          r_cost [tlc_pkg::NUM_REGS];
    tlc_pkg::t_copy          r_kind;
    logic                    r_l2_wr;
    logic                    r_hit;

    // Payload registers
    logic                    r_wr;
    logic [AW-1:0]           r_addr;
    logic [DW-1:0]           r_data;
    logic [DW-1:0]           r_start;
    logic                    r_l1hit;
    logic                    r_l2hit;
    logic [BLK_W-1:0]        r_l2_blk;
    logic [WYW-1:0]          r_hway;
    logic [WYW-1:0]          r_lway;
    logic [T2W-1:0]          r_ltag;
    logic [DW-1:0]           r_min;
    logic [LW-1:0]           r_line;
    logic [BLK_W-1:0]        r_mblk;
    logic [DW-1:0]           r_rd;
    logic [79:0]             r_out_data;

    // RAM ports
    logic                    l1t_we;
    logic [I1W-1:0]          l1t_waddr, l1t_raddr;
    logic [T1W-1:0]          l1t_wdata, l1t_rdata;
    logic                    l1w_we;
    logic [L1WA-1:0]         l1w_waddr, l1w_raddr;
    logic [DW-1:0]           l1w_wdata, l1w_rdata;
    logic                    l2m_we;
    logic [LW-1:0]           l2m_waddr, l2m_raddr;
    logic [MTW-1:0]          l2m_wdata, l2m_rdata;
    logic                    l2w_we;
    logic [L2WA-1:0]         l2w_waddr, l2w_raddr;
    logic [DW-1:0]           l2w_wdata, l2w_rdata;
    logic                    mem_we;
    logic [MWA-1:0]          mem_waddr, mem_raddr;
    logic [DW-1:0]           mem_wdata, mem_rdata;

    // Decoded request and L2 access fields
    logic [AW-1:0]           in_addr;
    logic [BLK_W-1:0]        in_blk;
    logic [BLK_W-1:0]        req_blk;
    logic [I1W-1:0]          req_idx;
    logic [T1W-1:0]          req_tag;
    logic [KW-1:0]           req_woff;
    logic [SW-1:0]           l2_set;
    logic [T2W-1:0]          l2_tag;
    logic [LW-1:0]           scan_line;
    logic [LW-1:0]           sel_line;
    logic                    l1_hit_now;
    logic                    scan_vld;
    logic [DW-1:0]           scan_stamp;
    logic [T2W-1:0]          scan_tag;
    logic [KW-1:0]           k_rd, k_wr;
    logic                    cp_wr;
    logic [DW-1:0]           cp_data;
    tlc_pkg::t_cost          cp_cost;
    logic                    accept;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign in_addr   = AW'(s_axis_tdata[15:0]);
    assign in_blk    = BLK_W'(in_addr >> OB);
    assign req_blk   = BLK_W'(r_addr >> OB);
    assign req_idx   = I1W'(req_blk % L1_SLOTS);
    assign req_tag   = T1W'(req_blk / L1_SLOTS);
    assign req_woff  = KW'((r_addr % BLOCK_BYTES) / WB);
    assign l2_set    = SW'(r_l2_blk % L2_SETS);
    assign l2_tag    = T2W'(r_l2_blk / L2_SETS);
    assign scan_line = LW'(l2_set * L2_WAYS + r_way);
    assign sel_line  = LW'(l2_set * L2_WAYS + (r_hit ? r_hway : r_lway));
    assign l1_hit_now = r_l1_valid[req_idx] && (l1t_rdata == req_tag);
    assign scan_vld   = r_l2_valid[scan_line];
    assign scan_stamp = scan_vld ? l2m_rdata[MTW-1:T2W] : '0;
    assign scan_tag   = l2m_rdata[T2W-1:0];
    assign k_rd       = KW'(r_cnt);
    assign k_wr       = KW'(r_cnt - CW'(1));
    assign cp_wr      = (r_state == S_COPY) && (r_cnt != '0);

    // Pick copy source data and cost by copy kind
    always_comb begin
        case (r_kind)
            tlc_pkg::CP_L2_MEM: begin
                cp_data = l2w_rdata;
                cp_cost = r_cost[tlc_pkg::REG_MEM_WR];
            end
            tlc_pkg::CP_MEM_L2: begin
                cp_data = mem_rdata;
                cp_cost = r_cost[tlc_pkg::REG_MEM_RD];
            end
            tlc_pkg::CP_L1_L2: begin
                cp_data = l1w_rdata;
                cp_cost = r_cost[tlc_pkg::REG_L2_WR];
            end
            default: begin
                cp_data = l2w_rdata;
                cp_cost = r_cost[tlc_pkg::REG_L2_RD];
            end
        endcase
    end

    // Drive RAM ports from the sequencer
    always_comb begin
        l1t_we    = 1'b0;
        l1t_waddr = req_idx;
        l1t_wdata = req_tag;
        l1t_raddr = I1W'(in_blk % L1_SLOTS);

        l1w_we    = 1'b0;
        l1w_waddr = L1WA'(req_idx * WPB + req_woff);
        l1w_wdata = r_data;
        l1w_raddr = L1WA'(req_idx * WPB + req_woff);

        l2m_we    = 1'b0;
        l2m_waddr = r_line;
        l2m_wdata = {r_time, l2_tag};
        l2m_raddr = scan_line;

        l2w_we    = 1'b0;
        l2w_waddr = L2WA'(r_line * WPB + k_wr);
        l2w_wdata = cp_data;
        l2w_raddr = L2WA'(r_line * WPB + k_rd);

        mem_we    = 1'b0;
        mem_waddr = MWA'(r_mblk * WPB + k_wr);
        mem_wdata = cp_data;
        mem_raddr = MWA'(r_mblk * WPB + k_rd);

        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_COPY: begin
                if (r_kind == tlc_pkg::CP_L2_L1) begin
                    l1w_waddr = L1WA'(req_idx * WPB + k_wr);
                    l1w_wdata = cp_data;
                    l1w_we    = cp_wr;
                end else begin
                    l1w_raddr = L1WA'(req_idx * WPB + k_rd);
                end
                if (r_kind == tlc_pkg::CP_L2_MEM) begin
                    mem_we = cp_wr;
                end
                if (r_kind == tlc_pkg::CP_MEM_L2 || r_kind == tlc_pkg::CP_L1_L2) begin
                    l2w_we = cp_wr;
                end
            end
            S_AFTER: begin
                if (r_kind == tlc_pkg::CP_MEM_L2) begin
                    l2m_we = 1'b1;
                end else if (r_kind == tlc_pkg::CP_L1_L2 || r_kind == tlc_pkg::CP_L2_L1) begin
                    l2m_we = r_hit;
                end
                if (r_kind == tlc_pkg::CP_L2_L1 && !r_l2_wr) begin
                    l1t_we = 1'b1;
                end
            end
            S_WORD: begin
                l1w_we = r_wr;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, flags, time counter and cost registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_way      <= '0;
            r_clr      <= '0;
            r_out_vld  <= 1'b0;
            r_l1_valid <= '0;
            r_l1_dirty <= '0;
            r_l2_valid <= '0;
            r_l2_dirty <= '0;
            r_time     <= '0;
            r_kind     <= tlc_pkg::CP_L2_L1;
            r_l2_wr    <= 1'b0;
            r_hit      <= 1'b0;
            r_cost[tlc_pkg::REG_L1_RD]  <= tlc_pkg::COST_L1_RD_RST;
            r_cost[tlc_pkg::REG_L1_WR]  <= tlc_pkg::COST_L1_WR_RST;
            r_cost[tlc_pkg::REG_L2_RD]  <= tlc_pkg::COST_L2_RD_RST;
            r_cost[tlc_pkg::REG_L2_WR]  <= tlc_pkg::COST_L2_WR_RST;
            r_cost[tlc_pkg::REG_MEM_RD] <= tlc_pkg::COST_MEM_RD_RST;
            r_cost[tlc_pkg::REG_MEM_WR] <= tlc_pkg::COST_MEM_WR_RST;
        end else begin
            // Take cost register writes, drop out-of-range indexes
            if (i_cfg_we && (i_cfg_idx < tlc_pkg::REG_IDX_W'(tlc_pkg::NUM_REGS))) begin
                r_cost[i_cfg_idx] <= i_cfg_data;
            end

            // Drop the result once taken, unless a new one is loaded now
            if (m_axis_tready && (r_state != S_FIN)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + MWA'(1);
                    if (r_clr == MWA'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_L1TAG;
                    end
                end
                S_L1TAG: begin
                    r_way <= '0;
                    r_hit <= 1'b0;
                    if (l1_hit_now) begin
                        r_state <= S_WORD;
                    end else begin
                        r_l2_wr <= r_l1_valid[req_idx] && r_l1_dirty[req_idx];
                        r_state <= S_L2RD;
                    end
                end
                S_L2RD: begin
                    r_state <= S_L2CK;
                end
                S_L2CK: begin
                    if (!r_hit && scan_vld && (scan_tag == l2_tag)) begin
                        r_hit <= 1'b1;
                    end
                    if (r_way == WYW'(L2_WAYS - 1)) begin
                        r_state <= S_L2SEL;
                    end else begin
                        r_way   <= r_way + WYW'(1);
                        r_state <= S_L2RD;
                    end
                end
                S_L2SEL: begin
                    r_cnt   <= '0;
                    r_state <= S_COPY;
                    if (r_hit) begin
                        r_kind <= r_l2_wr ? tlc_pkg::CP_L1_L2 : tlc_pkg::CP_L2_L1;
                    end else if (r_l2_valid[sel_line] && r_l2_dirty[sel_line]) begin
                        r_kind <= tlc_pkg::CP_L2_MEM;
                    end else begin
                        r_kind <= tlc_pkg::CP_MEM_L2;
                    end
                end
                S_COPY: begin
                    if (r_cnt == CW'(WPB)) begin
                        r_time  <= r_time + DW'(cp_cost);
                        r_state <= S_AFTER;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_AFTER: begin
                    r_cnt <= '0;
                    case (r_kind)
                        tlc_pkg::CP_L2_MEM: begin
                            r_kind  <= tlc_pkg::CP_MEM_L2;
                            r_state <= S_COPY;
                        end
                        tlc_pkg::CP_MEM_L2: begin
                            r_l2_valid[r_line] <= 1'b1;
                            r_l2_dirty[r_line] <= 1'b0;
                            r_kind  <= r_l2_wr ? tlc_pkg::CP_L1_L2 : tlc_pkg::CP_L2_L1;
                            r_state <= S_COPY;
                        end
                        tlc_pkg::CP_L1_L2: begin
                            r_l2_dirty[r_line] <= 1'b1;
                            r_l2_wr <= 1'b0;
                            r_way   <= '0;
                            r_hit   <= 1'b0;
                            r_state <= S_L2RD;
                        end
                        default: begin
                            r_l1_valid[req_idx] <= 1'b1;
                            r_l1_dirty[req_idx] <= 1'b0;
                            r_state <= S_WORD;
                        end
                    endcase
                end
                S_WORD: begin
                    if (r_wr) begin
                        r_l1_dirty[req_idx] <= 1'b1;
                        r_time  <= r_time + DW'(r_cost[tlc_pkg::REG_L1_WR]);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_WRD;
                    end
                end
                S_WRD: begin
                    r_time  <= r_time + DW'(r_cost[tlc_pkg::REG_L1_RD]);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request payload, L2 scan results and the result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr    <= s_axis_tuser;
            r_addr  <= in_addr;
            r_data  <= s_axis_tdata[47:16];
            r_start <= r_time;
            r_l2hit <= 1'b0;
        end
        case (r_state)
            S_L1TAG: begin
                r_l1hit <= l1_hit_now;
                if (r_l1_valid[req_idx] && r_l1_dirty[req_idx]) begin
                    r_l2_blk <= BLK_W'(l1t_rdata * L1_SLOTS + req_idx);
                end else begin
                    r_l2_blk <= req_blk;
                end
            end
            S_L2CK: begin
                if (!r_hit && scan_vld && (scan_tag == l2_tag)) begin
                    r_hway <= r_way;
                end
                if (r_way == '0 || scan_stamp < r_min) begin
                    r_min  <= scan_stamp;
                    r_lway <= r_way;
                    r_ltag <= scan_tag;
                end
            end
            S_L2SEL: begin
                r_line <= sel_line;
                if (!r_hit && r_l2_valid[sel_line] && r_l2_dirty[sel_line]) begin
                    r_mblk <= BLK_W'(r_ltag * L2_SETS + l2_set);
                end else begin
                    r_mblk <= r_l2_blk;
                end
            end
            S_AFTER: begin
                if (r_kind == tlc_pkg::CP_L2_MEM) begin
                    r_mblk <= r_l2_blk;
                end
                if (r_kind == tlc_pkg::CP_L1_L2) begin
                    r_l2_blk <= req_blk;
                end
                if (r_kind == tlc_pkg::CP_L2_L1) begin
                    r_l2hit <= r_hit;
                end
            end
            S_WORD: begin
                r_rd <= '0;
            end
            S_WRD: begin
                r_rd <= l1w_rdata;
            end
            S_FIN: begin
                if (!r_out_vld || m_axis_tready) begin
                    r_out_data <= {2'b00, r_time, tlc_pkg::ACC_W'(r_time - r_start),
                                   r_l2hit, r_l1hit, r_rd};
                end
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // L1 tag store
    tlc_ram #(.WIDTH(T1W), .DEPTH(L1_SLOTS)) u_l1_tag (
        .i_clk   (i_clk),
        .i_we    (l1t_we),
        .i_waddr (l1t_waddr),
        .i_wdata (l1t_wdata),
        .i_raddr (l1t_raddr),
        .o_rdata (l1t_rdata)
    );

    // L1 data store
    tlc_ram #(.WIDTH(DW), .DEPTH(L1_SLOTS * WPB)) u_l1_words (
        .i_clk   (i_clk),
        .i_we    (l1w_we),
        .i_waddr (l1w_waddr),
        .i_wdata (l1w_wdata),
        .i_raddr (l1w_raddr),
        .o_rdata (l1w_rdata)
    );

    // L2 stamp and tag store
    tlc_ram #(.WIDTH(MTW), .DEPTH(L2_SLOTS)) u_l2_meta (
        .i_clk   (i_clk),
        .i_we    (l2m_we),
        .i_waddr (l2m_waddr),
        .i_wdata (l2m_wdata),
        .i_raddr (l2m_raddr),
        .o_rdata (l2m_rdata)
    );

    // L2 data store
    tlc_ram #(.WIDTH(DW), .DEPTH(L2_SLOTS * WPB)) u_l2_words (
        .i_clk   (i_clk),
        .i_we    (l2w_we),
        .i_waddr (l2w_waddr),
        .i_wdata (l2w_wdata),
        .i_raddr (l2w_raddr),
        .o_rdata (l2w_rdata)
    );

    // Backing memory
    tlc_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_backing (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // An accepted item always starts with the L1 tag check
    a_accept_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_L1TAG))
        else $error("accepted item did not go to the L1 tag check");

    // Copy counter never runs past one block
    a_copy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_cnt <= CW'(WPB)))
        else $error("block copy counter overran");

    // Scan way stays within the set
    a_scan_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L2CK) |-> (r_way <= WYW'(L2_WAYS - 1)))
        else $error("L2 scan way out of range");

    // An L1 hit never reports an L2 hit
    a_hit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data[32]) |-> !r_out_data[33])
        else $error("L2 hit flagged on an L1 hit");

endmodule
